FILE: rtl/lcos_pkg.sv
// ----------------------------------------------------------------------------
// lcos_pkg
// shared widths, reset values and types of the line centroid offset smoother
// ----------------------------------------------------------------------------
package lcos_pkg;

   localparam int CHANNELS     = 7;
   localparam int SAMPLE_BITS  = 12;
   localparam int CH_BITS      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int THR_BITS     = 12;
   localparam int CENTER_BITS  = 11;
   localparam int SCALE_BITS   = 16;
   localparam int ALPHA_BITS   = 9;
   localparam int OFS_BITS     = 20;

   // centroid in q8, at most (CHANNELS-1)*256
   localparam int FRAC_BITS    = 8;
   localparam int POS_BITS     = 11;

   localparam logic [THR_BITS-1:0]    THRESHOLD_RESET = THR_BITS'(0);
   localparam logic [CENTER_BITS-1:0] CENTER_RESET    = CENTER_BITS'(768);
   localparam logic [SCALE_BITS-1:0]  SCALE_RESET     = SCALE_BITS'(256);
   localparam logic [ALPHA_BITS-1:0]  ALPHA_RESET     = ALPHA_BITS'(64);

   typedef struct packed {
      logic [CENTER_BITS-1:0] center_q8;
      logic [SCALE_BITS-1:0]  scale_q8;
      logic [ALPHA_BITS-1:0]  alpha_q8;
   } back_cfg_type;

endpackage

FILE: rtl/lcos_fifo.sv
// ----------------------------------------------------------------------------
// lcos_fifo
// two-entry queue between the accumulating front and the arithmetic back
// ----------------------------------------------------------------------------
module lcos_fifo #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: rtl/lcos_front.sv
// ----------------------------------------------------------------------------
// lcos_front
// takes a request and accumulates the weight sums one channel per cycle
// ----------------------------------------------------------------------------
module lcos_front #(
   parameter int SAMPLE_BITS = lcos_pkg::SAMPLE_BITS,
   parameter int SW_BITS     = SAMPLE_BITS + 3,
   parameter int IW_BITS     = SAMPLE_BITS + 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [SAMPLE_BITS-1:0]        samples [lcos_pkg::CHANNELS],
   input  logic [lcos_pkg::THR_BITS-1:0] threshold,
   output logic                          q_push,
   output logic [SW_BITS+IW_BITS-1:0]    q_data,
   input  logic                          q_full
);

   localparam int CH    = lcos_pkg::CHANNELS;
   localparam int CHB   = lcos_pkg::CH_BITS;
   localparam int EW    = (SAMPLE_BITS > lcos_pkg::THR_BITS) ? SAMPLE_BITS
                                                            : lcos_pkg::THR_BITS;
   localparam logic [CHB-1:0] LAST_CH = CHB'(CH - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ACC,
      S_PUSH
   } state_type;

   state_type              state_ff, state_in;
   logic [SAMPLE_BITS-1:0] samp_ff [CH];
   logic [SAMPLE_BITS-1:0] samp_in [CH];
   logic [CHB-1:0]         ch_ff, ch_in;
   logic [SW_BITS-1:0]     sum_w_ff, sum_w_in;
   logic [IW_BITS-1:0]     sum_iw_ff, sum_iw_in;
   logic [EW-1:0]          s_ext, t_ext, diff;
   logic [SAMPLE_BITS-1:0] weight;

   assign full   = (state_ff != S_IDLE);
   assign q_push = (state_ff == S_PUSH);
   assign q_data = {sum_w_ff, sum_iw_ff};

   always_comb begin
      s_ext  = EW'(samp_ff[0]);
      t_ext  = EW'(threshold);
      diff   = s_ext - t_ext;
      weight = (s_ext > t_ext) ? diff[SAMPLE_BITS-1:0] : '0;
   end

   always_comb begin
      state_in  = state_ff;
      ch_in     = ch_ff;
      sum_w_in  = sum_w_ff;
      sum_iw_in = sum_iw_ff;
      samp_in   = samp_ff;
      case (state_ff)
         S_IDLE: begin
            if (push) begin
               samp_in   = samples;
               ch_in     = '0;
               sum_w_in  = '0;
               sum_iw_in = '0;
               state_in  = S_ACC;
            end
         end
         S_ACC: begin
            sum_w_in  = sum_w_ff + SW_BITS'(weight);
            sum_iw_in = sum_iw_ff + IW_BITS'(ch_ff) * IW_BITS'(weight);
            for (int i = 0; i < CH - 1; i++) begin
               samp_in[i] = samp_ff[i+1];
            end
            ch_in = ch_ff + CHB'(1);
            if (ch_ff == LAST_CH) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (!q_full) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ch_ff    <= '0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
      end
   end

   always_ff @(posedge clock) begin
      samp_ff   <= samp_in;
      sum_w_ff  <= sum_w_in;
      sum_iw_ff <= sum_iw_in;
   end

endmodule

FILE: rtl/lcos_back.sv
// ----------------------------------------------------------------------------
// lcos_back
// serial centroid division, gain, moving-average update and result register
// ----------------------------------------------------------------------------
module lcos_back #(
   parameter int SAMPLE_BITS = lcos_pkg::SAMPLE_BITS,
   parameter int SW_BITS     = SAMPLE_BITS + 3,
   parameter int IW_BITS     = SAMPLE_BITS + 6
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [SW_BITS+IW_BITS-1:0]         q_data,
   input  logic                               q_empty,
   output logic                               q_pop,
   input  lcos_pkg::back_cfg_type             cfg,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic signed [lcos_pkg::OFS_BITS-1:0] rsp_offset,
   output logic                               rsp_line_seen
);

   localparam int PB    = lcos_pkg::POS_BITS;
   localparam int FB    = lcos_pkg::FRAC_BITS;
   localparam int HB    = PB - FB;
   localparam int RW    = SW_BITS + 1;
   localparam int OB    = lcos_pkg::OFS_BITS;
   localparam int DW    = lcos_pkg::CENTER_BITS + 2;
   localparam int PAW   = DW + lcos_pkg::SCALE_BITS + 1;
   localparam int PBW   = OB + 1 + lcos_pkg::ALPHA_BITS + 1;
   localparam int CB    = $clog2(PB + 1);
   localparam logic [CB-1:0] LAST_BIT = CB'(PB - 1);
   localparam logic signed [PBW-1:0] OFS_MAX = PBW'((64'sd1 <<< (OB - 1)) - 1);
   localparam logic signed [PBW-1:0] OFS_MIN = -PBW'(64'sd1 <<< (OB - 1));

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_MULA,
      S_MULB,
      S_UPD,
      S_OUT
   } state_type;

   state_type                   state_ff, state_in;
   logic [SW_BITS-1:0]          den_ff, den_in;
   logic [RW-1:0]               rem_ff, rem_in;
   logic [PB-1:0]               low_ff, low_in;
   logic [PB-1:0]               quo_ff, quo_in;
   logic [CB-1:0]               cnt_ff, cnt_in;
   logic                        lost_ff, lost_in;
   logic signed [PAW-1:0]       prod_a_ff, prod_a_in;
   logic signed [PBW-1:0]       prod_b_ff, prod_b_in;
   logic signed [OB-1:0]        avg_ff, avg_in;
   logic                        out_valid_ff, out_valid_in;
   logic signed [OB-1:0]        out_offset_ff, out_offset_in;
   logic                        out_seen_ff, out_seen_in;

   logic [SW_BITS-1:0]          q_sum_w;
   logic [IW_BITS-1:0]          q_sum_iw;
   logic [RW-1:0]               trial;
   logic signed [DW-1:0]        diff;
   logic signed [PAW-1:0]       raw_wide;
   logic signed [OB-1:0]        raw;
   logic signed [OB:0]          delta;
   logic signed [PBW-1:0]       upd;
   logic                        out_free;

   function automatic logic signed [OB-1:0] sat_ofs(input logic signed [PBW-1:0] x);
      logic signed [OB-1:0] r;
      if (x > OFS_MAX) begin
         r = OFS_MAX[OB-1:0];
      end else if (x < OFS_MIN) begin
         r = OFS_MIN[OB-1:0];
      end else begin
         r = x[OB-1:0];
      end
      return r;
   endfunction

   assign q_sum_w       = q_data[SW_BITS+IW_BITS-1:IW_BITS];
   assign q_sum_iw      = q_data[IW_BITS-1:0];
   assign q_pop         = (state_ff == S_IDLE) && !q_empty;
   assign out_free      = !out_valid_ff || rsp_pop;
   assign rsp_empty     = !out_valid_ff;
   assign rsp_offset    = out_offset_ff;
   assign rsp_line_seen = out_seen_ff;

   always_comb begin
      trial    = {rem_ff[RW-2:0], low_ff[PB-1]};
      diff     = $signed({2'b00, quo_ff}) - $signed({2'b00, cfg.center_q8});
      raw_wide = prod_a_ff >>> FB;
      raw      = sat_ofs(PBW'(raw_wide));
      delta    = $signed({raw[OB-1], raw}) - $signed({avg_ff[OB-1], avg_ff});
      upd      = PBW'(avg_ff) + (prod_b_ff >>> FB);
   end

   always_comb begin
      state_in      = state_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      low_in        = low_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      lost_in       = lost_ff;
      prod_a_in     = prod_a_ff;
      prod_b_in     = prod_b_ff;
      avg_in        = avg_ff;
      out_valid_in  = out_valid_ff && !rsp_pop;
      out_offset_in = out_offset_ff;
      out_seen_in   = out_seen_ff;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               den_in  = q_sum_w;
               rem_in  = RW'(q_sum_iw >> HB);
               low_in  = {q_sum_iw[HB-1:0], FB'(0)};
               quo_in  = '0;
               cnt_in  = '0;
               lost_in = (q_sum_w == '0);
               state_in = (q_sum_w == '0) ? S_OUT : S_DIV;
            end
         end
         S_DIV: begin
            low_in = {low_ff[PB-2:0], 1'b0};
            if (trial >= RW'(den_ff)) begin
               rem_in = trial - RW'(den_ff);
               quo_in = {quo_ff[PB-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[PB-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CB'(1);
            if (cnt_ff == LAST_BIT) begin
               state_in = S_MULA;
            end
         end
         S_MULA: begin
            prod_a_in = PAW'(diff) * PAW'($signed({1'b0, cfg.scale_q8}));
            state_in  = S_MULB;
         end
         S_MULB: begin
            prod_b_in = PBW'(delta) * PBW'($signed({1'b0, cfg.alpha_q8}));
            state_in  = S_UPD;
         end
         S_UPD: begin
            avg_in   = sat_ofs(upd);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_offset_in = avg_ff;
               out_seen_in   = !lost_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         avg_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         avg_ff       <= avg_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff        <= den_in;
      rem_ff        <= rem_in;
      low_ff        <= low_in;
      quo_ff        <= quo_in;
      lost_ff       <= lost_in;
      prod_a_ff     <= prod_a_in;
      prod_b_ff     <= prod_b_in;
      out_offset_ff <= out_offset_in;
      out_seen_ff   <= out_seen_in;
   end

endmodule

FILE: rtl/line_centroid_offset_smoother.sv
// ----------------------------------------------------------------------------
// line_centroid_offset_smoother
// weighted centroid of a line-sensor frame, scaled and smoothed offset
// ----------------------------------------------------------------------------
// A request is one frame of seven samples; each yields exactly one response
// with the smoothed offset (q8, two's complement) and a line_seen flag. The
// front takes a frame and sums the channel weights one channel per cycle;
// a two-entry queue feeds the back, which runs a serial divider for the
// centroid, two multiplies and an update. The front takes no new frame
// until it has pushed the last one into the queue, and the back holds its
// result until the response register is free. A frame with no channel above
// threshold skips the arithmetic and returns the held value.
// Registers: 0x0 threshold, 0x4 center_q8, 0x8 scale_q8, 0xc alpha_q8.
// ----------------------------------------------------------------------------
module line_centroid_offset_smoother #(
   parameter int SAMPLE_BITS = lcos_pkg::SAMPLE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [SAMPLE_BITS-1:0]             req_sample_0,
   input  logic [SAMPLE_BITS-1:0]             req_sample_1,
   input  logic [SAMPLE_BITS-1:0]             req_sample_2,
   input  logic [SAMPLE_BITS-1:0]             req_sample_3,
   input  logic [SAMPLE_BITS-1:0]             req_sample_4,
   input  logic [SAMPLE_BITS-1:0]             req_sample_5,
   input  logic [SAMPLE_BITS-1:0]             req_sample_6,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic signed [lcos_pkg::OFS_BITS-1:0] rsp_offset,
   output logic                               rsp_line_seen,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [3:0]                         csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   localparam int SW_BITS = SAMPLE_BITS + 3;
   localparam int IW_BITS = SAMPLE_BITS + 6;

   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_CENTER    = 2'd1;
   localparam logic [1:0] REG_SCALE     = 2'd2;
   localparam logic [1:0] REG_ALPHA     = 2'd3;

   logic [lcos_pkg::THR_BITS-1:0]    threshold_ff;
   logic [lcos_pkg::CENTER_BITS-1:0] center_ff;
   logic [lcos_pkg::SCALE_BITS-1:0]  scale_ff;
   logic [lcos_pkg::ALPHA_BITS-1:0]  alpha_ff;
   logic                             csr_write;
   logic [1:0]                       csr_index;
   lcos_pkg::back_cfg_type           back_cfg;

   logic [SAMPLE_BITS-1:0]           samples [lcos_pkg::CHANNELS];
   logic                             q_push, q_full, q_pop, q_empty;
   logic [SW_BITS+IW_BITS-1:0]       q_wdata, q_rdata;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= lcos_pkg::THRESHOLD_RESET;
         center_ff    <= lcos_pkg::CENTER_RESET;
         scale_ff     <= lcos_pkg::SCALE_RESET;
         alpha_ff     <= lcos_pkg::ALPHA_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_THRESHOLD: threshold_ff <= csr_pwdata[lcos_pkg::THR_BITS-1:0];
            REG_CENTER:    center_ff    <= csr_pwdata[lcos_pkg::CENTER_BITS-1:0];
            REG_SCALE:     scale_ff     <= csr_pwdata[lcos_pkg::SCALE_BITS-1:0];
            REG_ALPHA:     alpha_ff     <= csr_pwdata[lcos_pkg::ALPHA_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_THRESHOLD: csr_prdata = 32'(threshold_ff);
         REG_CENTER:    csr_prdata = 32'(center_ff);
         REG_SCALE:     csr_prdata = 32'(scale_ff);
         REG_ALPHA:     csr_prdata = 32'(alpha_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign back_cfg.center_q8 = center_ff;
   assign back_cfg.scale_q8  = scale_ff;
   assign back_cfg.alpha_q8  = alpha_ff;

   assign samples[0] = req_sample_0;
   assign samples[1] = req_sample_1;
   assign samples[2] = req_sample_2;
   assign samples[3] = req_sample_3;
   assign samples[4] = req_sample_4;
   assign samples[5] = req_sample_5;
   assign samples[6] = req_sample_6;

   lcos_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .SW_BITS     (SW_BITS),
      .IW_BITS     (IW_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .samples   (samples),
      .threshold (threshold_ff),
      .q_push    (q_push),
      .q_data    (q_wdata),
      .q_full    (q_full)
   );

   lcos_fifo #(
      .WIDTH (SW_BITS + IW_BITS)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   lcos_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .SW_BITS     (SW_BITS),
      .IW_BITS     (IW_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_data        (q_rdata),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .cfg           (back_cfg),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_offset    (rsp_offset),
      .rsp_line_seen (rsp_line_seen)
   );

endmodule

FILE: test/lcos_tb_pkg.sv
// ----------------------------------------------------------------------------
// lcos_tb_pkg
// register indexes and the frame type shared by the smoother testbench files
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcos_tb_pkg;

   typedef enum logic [1:0] {
      REG_THRESHOLD = 2'd0,
      REG_CENTER    = 2'd1,
      REG_SCALE     = 2'd2,
      REG_ALPHA     = 2'd3
   } csr_index_type;

   typedef logic [lcos_pkg::CHANNELS-1:0][lcos_pkg::SAMPLE_BITS-1:0] sample_frame_type;

endpackage

FILE: test/line_centroid_offset_smoother_checker.sv
// ----------------------------------------------------------------------------
// line_centroid_offset_smoother_checker
// Watches the request, response and register ports of the smoother. It keeps
// its own copy of the registers and of the smoothed offset, works out the
// response of every accepted request and compares each popped response with
// the oldest one waiting, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_centroid_offset_smoother_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   input  logic                             req_full,
   input  lcos_tb_pkg::sample_frame_type    req_frame,
   input  logic                             rsp_empty,
   input  logic                             rsp_pop,
   input  logic signed [lcos_pkg::OFS_BITS-1:0] rsp_offset,
   input  logic                             rsp_line_seen,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [3:0]                       csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   input  logic                             csr_pready,
   output int                               mismatches,
   output int                               outstanding,
   output int                               frames_checked,
   output int                               frames_lost
);

   localparam int OFS_BITS = lcos_pkg::OFS_BITS;

   typedef struct packed {
      logic signed [OFS_BITS-1:0] offset;
      logic                       line_seen;
   } centroid_result_type;

   localparam longint OFS_HI = (64'sd1 <<< (OFS_BITS - 1)) - 1;
   localparam longint OFS_LO = -(64'sd1 <<< (OFS_BITS - 1));

   logic [lcos_pkg::THR_BITS-1:0]    threshold_q;
   logic [lcos_pkg::CENTER_BITS-1:0] center_q;
   logic [lcos_pkg::SCALE_BITS-1:0]  scale_q;
   logic [lcos_pkg::ALPHA_BITS-1:0]  alpha_q;
   logic signed [OFS_BITS-1:0]       smoothed_q;
   centroid_result_type              expected_offsets[$];

   function automatic longint clip_offset(input longint x);
      if (x > OFS_HI) return OFS_HI;
      if (x < OFS_LO) return OFS_LO;
      return x;
   endfunction

   // weighted centroid, gain and moving average; updates the smoothed offset
   function automatic centroid_result_type smooth_frame(
      input lcos_tb_pkg::sample_frame_type frame);
      centroid_result_type r;
      longint weight_sum, moment_sum, excess, pos, raw, step;
      weight_sum = 0;
      moment_sum = 0;
      for (int ch = 0; ch < lcos_pkg::CHANNELS; ch++) begin
         if (frame[ch] > threshold_q) begin
            excess = longint'(frame[ch]) - longint'(threshold_q);
            weight_sum += excess;
            moment_sum += ch * excess;
         end
      end
      if (weight_sum != 0) begin
         pos  = (moment_sum * 256) / weight_sum;
         raw  = clip_offset(((pos - longint'(center_q)) * longint'(scale_q))
                            >>> lcos_pkg::FRAC_BITS);
         step = ((raw - longint'(smoothed_q)) * longint'(alpha_q)) >>> lcos_pkg::FRAC_BITS;
         smoothed_q = OFS_BITS'(clip_offset(longint'(smoothed_q) + step));
      end
      r.offset    = smoothed_q;
      r.line_seen = (weight_sum != 0);
      return r;
   endfunction

   always @(posedge clock) begin
      centroid_result_type want;
      if (reset) begin
         threshold_q = lcos_pkg::THRESHOLD_RESET;
         center_q    = lcos_pkg::CENTER_RESET;
         scale_q     = lcos_pkg::SCALE_RESET;
         alpha_q     = lcos_pkg::ALPHA_RESET;
         smoothed_q  = '0;
         expected_offsets.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_offsets.size() == 0) begin
               $error("response with no request waiting: offset %0d line_seen %0b",
                      rsp_offset, rsp_line_seen);
               mismatches++;
            end else begin
               want = expected_offsets.pop_front();
               if (rsp_offset !== want.offset) begin
                  $error("offset: expected %0d, actual %0d", $signed(want.offset), rsp_offset);
                  mismatches++;
               end
               if (rsp_line_seen !== want.line_seen) begin
                  $error("line_seen: expected %0b, actual %0b", want.line_seen, rsp_line_seen);
                  mismatches++;
               end
               frames_checked++;
               if (!want.line_seen) frames_lost++;
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (lcos_tb_pkg::csr_index_type'(csr_paddr[3:2]))
               lcos_tb_pkg::REG_THRESHOLD:
                  threshold_q = csr_pwdata[lcos_pkg::THR_BITS-1:0];
               lcos_tb_pkg::REG_CENTER:
                  center_q    = csr_pwdata[lcos_pkg::CENTER_BITS-1:0];
               lcos_tb_pkg::REG_SCALE:
                  scale_q     = csr_pwdata[lcos_pkg::SCALE_BITS-1:0];
               lcos_tb_pkg::REG_ALPHA:
                  alpha_q     = csr_pwdata[lcos_pkg::ALPHA_BITS-1:0];
               default: ;
            endcase
         end
         if (req_push && !req_full) expected_offsets.push_back(smooth_frame(req_frame));
      end
      outstanding = expected_offsets.size();
   end

endmodule

FILE: test/line_centroid_offset_smoother_tb.sv
// ----------------------------------------------------------------------------
// line_centroid_offset_smoother_tb
// Drives sensor frames and register settings into the smoother: a directed
// set of extremes, lost lines and saturating updates, then random phases of
// line-shaped and noisy frames under random settings, with random idling on
// both sides, a long response stall and a full drain. The checker beside the
// block predicts and compares every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_centroid_offset_smoother_tb;

   localparam int SAMPLE_BITS = lcos_pkg::SAMPLE_BITS;
   localparam int CHANNELS    = lcos_pkg::CHANNELS;
   localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
   localparam int CENTER_MAX  = (1 << lcos_pkg::CENTER_BITS) - 1;
   localparam int SCALE_MAX   = (1 << lcos_pkg::SCALE_BITS) - 1;
   localparam int ALPHA_MAX   = (1 << lcos_pkg::ALPHA_BITS) - 1;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 60;
   localparam int LONG_HOLD   = 200;
   localparam int STALL_LIMIT = 5000;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_push = 1'b0;
   logic                                req_full;
   lcos_tb_pkg::sample_frame_type       req_frame = '0;
   logic                                rsp_empty;
   logic                                rsp_pop = 1'b0;
   logic signed [lcos_pkg::OFS_BITS-1:0] rsp_offset;
   logic                                rsp_line_seen;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [3:0]                          csr_paddr = '0;
   logic [31:0]                         csr_pwdata = '0;
   logic [31:0]                         csr_prdata;
   logic                                csr_pready;

   int  mismatches, outstanding, frames_checked, frames_lost;
   int  quiet_cycles = 0;
   int  full_cycles = 0;
   int  config_settings = 0;
   int  cur_threshold = 0;
   int  idle_pct = 0;
   bit  no_idle = 1'b0;
   bit  hold_off_req = 1'b0;

   line_centroid_offset_smoother dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_sample_0  (req_frame[0]),
      .req_sample_1  (req_frame[1]),
      .req_sample_2  (req_frame[2]),
      .req_sample_3  (req_frame[3]),
      .req_sample_4  (req_frame[4]),
      .req_sample_5  (req_frame[5]),
      .req_sample_6  (req_frame[6]),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_offset    (rsp_offset),
      .rsp_line_seen (rsp_line_seen),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   line_centroid_offset_smoother_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_frame      (req_frame),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_offset     (rsp_offset),
      .rsp_line_seen  (rsp_line_seen),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .frames_checked (frames_checked),
      .frames_lost    (frames_lost)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (req_push && req_full) full_cycles <= full_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("** line_centroid_offset_smoother: FAILED **");
         $finish;
      end
   end

   initial begin : response_drain
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_pop <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            hold_off_req = 1'b0;
         end else if (!no_idle && $urandom_range(0, 99) < idle_pct) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clock);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   function automatic logic [31:0] field_word(input int value, input int bits, input bit junk);
      if (junk) return ($urandom() << bits) | value;
      return value;
   endfunction

   function automatic lcos_tb_pkg::sample_frame_type random_frame(input int thr);
      lcos_tb_pkg::sample_frame_type f;
      int kind, mid, spread;
      kind   = $urandom_range(0, 9);
      mid    = $urandom_range(0, CHANNELS - 1);
      spread = $urandom_range(0, 2);
      for (int ch = 0; ch < CHANNELS; ch++) begin
         if (kind < 2)
            f[ch] = SAMPLE_BITS'($urandom());
         else if (kind == 2 || ch < mid - spread || ch > mid + spread)
            f[ch] = SAMPLE_BITS'($urandom_range(0, thr));
         else
            f[ch] = SAMPLE_BITS'($urandom_range(thr, SAMPLE_MAX));
      end
      return f;
   endfunction

   task automatic send_frame(input lcos_tb_pkg::sample_frame_type f);
      req_frame <= f;
      req_push  <= 1'b1;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   task automatic send_spike(input int ch, input int level);
      lcos_tb_pkg::sample_frame_type f;
      f     = '0;
      f[ch] = SAMPLE_BITS'(level);
      send_frame(f);
   endtask

   task automatic sender_gap();
      if (!no_idle && $urandom_range(0, 99) < idle_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   // psel stays high across back-to-back writes; set_config closes the burst
   task automatic write_reg(input lcos_tb_pkg::csr_index_type idx, input logic [31:0] value);
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      csr_pwrite  <= 1'b1;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
   endtask

   task automatic set_config(input int thr, input int ctr, input int scl, input int alp,
                             input bit junk);
      wait_drained();
      write_reg(lcos_tb_pkg::REG_THRESHOLD, field_word(thr, lcos_pkg::THR_BITS, junk));
      write_reg(lcos_tb_pkg::REG_CENTER, field_word(ctr, lcos_pkg::CENTER_BITS, junk));
      write_reg(lcos_tb_pkg::REG_SCALE, field_word(scl, lcos_pkg::SCALE_BITS, junk));
      write_reg(lcos_tb_pkg::REG_ALPHA, field_word(alp, lcos_pkg::ALPHA_BITS, junk));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      cur_threshold = thr;
      config_settings++;
   endtask

   initial begin : stimulus
      lcos_tb_pkg::sample_frame_type f;
      int thr, ctr, scl, alp;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register values out of reset
      send_frame('0);
      send_frame('1);
      send_spike(0, SAMPLE_MAX);
      send_spike(CHANNELS - 1, SAMPLE_MAX);
      for (int ch = 0; ch < CHANNELS; ch++) f[ch] = (ch % 2) ? '0 : SAMPLE_BITS'(SAMPLE_MAX);
      send_frame(f);
      send_spike(3, 1);

      // nothing can exceed the top threshold
      set_config(SAMPLE_MAX, CENTER_MAX, SCALE_MAX, ALPHA_MAX, 1'b0);
      send_frame('1);
      send_frame('0);

      // full-scale swings, then overshooting alpha into both limits
      set_config(0, CENTER_MAX, SCALE_MAX, 256, 1'b0);
      send_spike(0, SAMPLE_MAX);
      set_config(0, 0, SCALE_MAX, ALPHA_MAX, 1'b0);
      send_spike(CHANNELS - 1, SAMPLE_MAX);
      set_config(0, CENTER_MAX, SCALE_MAX, ALPHA_MAX, 1'b0);
      send_spike(0, SAMPLE_MAX);
      send_spike(0, SAMPLE_MAX);

      // samples equal to the threshold do not count; zero gain and weight
      set_config(2000, 768, 0, 0, 1'b0);
      f = {CHANNELS{SAMPLE_BITS'(2000)}};
      send_frame(f);
      send_spike(4, 2001);

      for (int p = 0; p < PHASES; p++) begin
         no_idle  = (p == PHASES - 1);
         idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 20 : 50);
         thr = ($urandom_range(0, 99) < 15) ? ($urandom_range(0, 1) ? SAMPLE_MAX : 0)
                                            : $urandom_range(0, 3500);
         ctr = ($urandom_range(0, 99) < 15) ? $urandom_range(1537, CENTER_MAX)
                                            : $urandom_range(0, 1536);
         if ($urandom_range(0, 99) < 10)
            scl = $urandom_range(0, 1) ? SCALE_MAX : 0;
         else
            scl = $urandom_range(0, 1) ? $urandom_range(0, 1024) : $urandom_range(0, SCALE_MAX);
         alp = ($urandom_range(0, 99) < 15) ? $urandom_range(257, ALPHA_MAX)
                                            : $urandom_range(0, 256);
         set_config(thr, ctr, scl, alp, 1'b1);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // long response stall while requests keep coming
            if (p == 2 && k == 10) hold_off_req = 1'b1;
            if (p == 5 && k == PHASE_ITEMS / 2) wait_drained();
            if (!(p == 2 && k >= 10 && k < 30)) sender_gap();
            send_frame(random_frame(cur_threshold));
         end
      end

      wait_drained();
      repeat (40) @(negedge clock);
      $display("covered %0d frames (%0d with the line lost) under %0d register settings",
               frames_checked, frames_lost, config_settings);
      $display("request side held off by a full block for %0d cycles", full_cycles);
      if (mismatches == 0 && outstanding == 0)
         $display("** line_centroid_offset_smoother: PASSED **");
      else
         $display("** line_centroid_offset_smoother: FAILED **");
      $finish;
   end

endmodule
